// ===== hdl/rsnp_pkg.sv =====
// Shared types and codes for the ready-set nearest-ticket picker.
// Used by rsnp_cell, ready_set_nearest_ticket_picker and rsnp_port_checker; depends on nothing.
`timescale 1ns / 1ps

package rsnp_pkg;

  // Command codes carried by an input beat.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_PICK   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Probe record that travels down the chain, one cell per cycle.
  // hit marks that an insert found a slot or a remove found its match.
  // have, best_delta, best_id and best_tk hold the best pick candidate so far.
  typedef struct packed {
    logic        valid;
    logic [1:0]  cmd;
    logic [15:0] tid;
    logic [7:0]  ticket;
    logic        hit;
    logic        have;
    logic [7:0]  best_delta;
    logic [15:0] best_id;
    logic [7:0]  best_tk;
  } probe_t;

endpackage

// ===== hdl/rsnp_cell.sv =====
// One slot of the ready table plus the probe register that follows it.
// Depends on rsnp_pkg for the probe record and the command codes.
`timescale 1ns / 1ps

module rsnp_cell
  import rsnp_pkg::*;
#(
  parameter int TICKET_LIMIT = 256
) (
  input  logic   clk,
  input  logic   rst,
  input  probe_t probe_in,
  output probe_t probe_out
);

  logic        valid;
  logic [15:0] id;
  logic [7:0]  tk;

  logic        valid_next;
  logic [15:0] id_next;
  logic [7:0]  tk_next;
  probe_t      probe_next;

  logic [7:0]  delta;
  logic        in_reach;
  logic        better;

  // Distance from the drawn ticket and the comparison against the best so far.
  always_comb begin
    delta    = (tk > probe_in.ticket) ? (tk - probe_in.ticket) : (probe_in.ticket - tk);
    in_reach = ({24'd0, delta} < 32'(TICKET_LIMIT));
    better   = !probe_in.have || (delta < probe_in.best_delta) ||
               ((delta == probe_in.best_delta) &&
                ((id < probe_in.best_id) ||
                 ((id == probe_in.best_id) && (tk < probe_in.best_tk))));
  end

  // Apply the passing command to this slot and update the probe.
  always_comb begin
    valid_next = valid;
    id_next    = id;
    tk_next    = tk;
    probe_next = probe_in;
    if (probe_in.valid) begin
      unique case (probe_in.cmd)
        CMD_INSERT: begin
          if (!probe_in.hit && !valid) begin
            valid_next     = 1'b1;
            id_next        = probe_in.tid;
            tk_next        = probe_in.ticket;
            probe_next.hit = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (!probe_in.hit && valid && (id == probe_in.tid) && (tk == probe_in.ticket)) begin
            valid_next     = 1'b0;
            probe_next.hit = 1'b1;
          end
        end
        CMD_PICK: begin
          if (valid && in_reach && better) begin
            probe_next.have       = 1'b1;
            probe_next.best_delta = delta;
            probe_next.best_id    = id;
            probe_next.best_tk    = tk;
          end
        end
        default: begin
          probe_next = probe_in;
        end
      endcase
    end
  end

  // Slot valid bit and probe valid bit are cleared by reset; payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= 1'b0;
      probe_out.valid <= 1'b0;
    end else begin
      valid     <= valid_next;
      probe_out <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    id <= id_next;
    tk <= tk_next;
  end

endmodule

// ===== hdl/ready_set_nearest_ticket_picker.sv =====
// Top level: input register, a chain of TABLE_DEPTH cells and the result register.
// Depends on rsnp_pkg and rsnp_cell.
// An item passes the input register, each cell in turn and then the result register.
// A new item is taken only once the last probe has left the last cell; the probe visits one cell per cycle.
// Reset clears every slot's valid bit, so the set is empty at once; no clearing pass.
// Each result is shown for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps

module ready_set_nearest_ticket_picker
  import rsnp_pkg::*;
#(
  parameter int TABLE_DEPTH  = 32,
  parameter int TICKET_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  cmd,
  input  logic [15:0] thread_id,
  input  logic [7:0]  ticket,
  output logic        busy,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [15:0] chosen_id,
  output logic [7:0]  chosen_ticket
);

  probe_t      chain [0:TABLE_DEPTH];
  probe_t      head;
  logic        accept;
  logic        busy_next;
  probe_t      last;
  logic [1:0]  status_next;
  logic [15:0] chosen_id_next;
  logic [7:0]  chosen_ticket_next;

  assign accept   = start && !busy;
  assign chain[0] = head;
  assign last     = chain[TABLE_DEPTH];

  // Busy from the accepting edge until the probe leaves the last cell.
  always_comb begin
    busy_next = busy;
    if (accept) begin
      busy_next = 1'b1;
    end else if (last.valid) begin
      busy_next = 1'b0;
    end
  end

  // Launch a fresh probe into the head of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      head.valid <= 1'b0;
    end else begin
      busy       <= busy_next;
      head.valid <= accept;
      if (accept) begin
        head.cmd        <= cmd;
        head.tid        <= thread_id;
        head.ticket     <= ticket;
        head.hit        <= 1'b0;
        head.have       <= 1'b0;
        head.best_delta <= 8'd0;
        head.best_id    <= 16'd0;
        head.best_tk    <= 8'd0;
      end
    end
  end

  // Row of table cells, each passing the probe to its neighbor.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    rsnp_cell #(
      .TICKET_LIMIT(TICKET_LIMIT)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe_in (chain[g]),
      .probe_out(chain[g+1])
    );
  end

  // Turn the finished probe into a result beat.
  always_comb begin
    status_next        = ST_MISS;
    chosen_id_next     = 16'd0;
    chosen_ticket_next = 8'd0;
    unique case (last.cmd)
      CMD_INSERT: begin
        status_next = last.hit ? ST_DONE : ST_FULL;
      end
      CMD_REMOVE: begin
        status_next = last.hit ? ST_DONE : ST_MISS;
      end
      CMD_PICK: begin
        if (last.have) begin
          status_next        = ST_DONE;
          chosen_id_next     = last.best_id;
          chosen_ticket_next = last.best_tk;
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      status        <= status_next;
      chosen_id     <= chosen_id_next;
      chosen_ticket <= chosen_ticket_next;
    end
  end

endmodule

// ===== hdl/rsnp_checker.sv =====
// Port-level checks for ready_set_nearest_ticket_picker, attached by bind.
// Depends on rsnp_pkg for the status codes.
`timescale 1ns / 1ps

module rsnp_port_checker
  import rsnp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic [1:0]  cmd,
  input logic [15:0] thread_id,
  input logic [7:0]  ticket,
  input logic        busy,
  input logic        result_valid,
  input logic [1:0]  status,
  input logic [15:0] chosen_id,
  input logic [7:0]  chosen_ticket
);

  // An accepted beat holds the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  // A result strobe lasts one cycle, since only one item is in flight.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  // A result only follows a busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a pending item");

  // Any result whose status is not done reports zero id and ticket.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != ST_DONE)) |-> ((chosen_id == 16'd0) && (chosen_ticket == 8'd0)))
    else $error("nonzero chosen fields on a failed result");

endmodule

bind ready_set_nearest_ticket_picker rsnp_port_checker u_rsnp_checker (.*);
